### hw/rtl/poi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Planar odometry integrator package
// Constants, divisor tables and the request and result bundles of the
// sine and cosine unit.
// ----------------------------------------------------------------------------
package poi_pkg;

    // pi in Q30 and 2^32 / (2 pi), rounded.
    localparam logic [31:0] PI_Q30         = 32'hC90F_DAA2;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
    localparam logic [29:0] EIGHTH_TURN    = 30'h2000_0000;

    typedef struct packed {
        logic        start;
        logic [31:0] phase;
    } t_sc_req;

    typedef struct packed {
        logic        done;
        logic [31:0] sin_q30;
        logic [31:0] cos_q30;
    } t_sc_res;

    // Horner divisors of the sine series, innermost term first.
    function automatic logic [7:0] sin_divisor(input logic [2:0] k);
        logic [7:0] d;
        unique case (k)
            3'd0:    d = 8'd110;
            3'd1:    d = 8'd72;
            3'd2:    d = 8'd42;
            3'd3:    d = 8'd20;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

    // Horner divisors of the cosine series, innermost term first.
    function automatic logic [7:0] cos_divisor(input logic [2:0] k);
        logic [7:0] d;
        unique case (k)
            3'd0:    d = 8'd132;
            3'd1:    d = 8'd90;
            3'd2:    d = 8'd56;
            3'd3:    d = 8'd30;
            3'd4:    d = 8'd12;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/poi_sincos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Planar odometry sine and cosine unit
// Folds a 32-bit phase into one eighth of a turn and evaluates the Taylor
// series with a bit-serial multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
module poi_sincos
    import poi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_sc_req i_req,
    output t_sc_res o_res
);

    typedef enum logic [7:0] {
        SC_IDLE  = 8'b0000_0001,
        SC_XMUL  = 8'b0000_0010,
        SC_X2MUL = 8'b0000_0100,
        SC_SMUL  = 8'b0000_1000,
        SC_SDIV  = 8'b0001_0000,
        SC_SNMUL = 8'b0010_0000,
        SC_CMUL  = 8'b0100_0000,
        SC_CDIV  = 8'b1000_0000
    } t_sc_state;

    t_sc_state   r_state;
    logic        r_go_mul;
    logic        r_go_div;
    logic [1:0]  r_quad;
    logic        r_mirror;
    logic [29:0] r_fold;
    logic [30:0] r_x;
    logic [30:0] r_x2;
    logic [30:0] r_t;
    logic [30:0] r_sn;
    logic [2:0]  r_k;
    logic [63:0] r_ma;
    logic [31:0] r_mb;
    logic [63:0] r_acc;
    logic        r_mbusy;
    logic [31:0] r_dn;
    logic [7:0]  r_dd;
    logic [7:0]  r_rem;
    logic [5:0]  r_dcnt;
    logic        r_dbusy;
    logic        r_done;
    logic [31:0] r_sin;
    logic [31:0] r_cos;

    logic [29:0] n_frac;
    logic        n_mirror;
    logic [30:0] n_fold_w;
    logic [29:0] n_fold;
    logic [63:0] n_ma;
    logic [31:0] n_mb;
    logic [7:0]  n_dden;
    logic [63:0] n_xsum;
    logic [63:0] n_x2sum;
    logic [8:0]  n_rem_sh;
    logic        n_ge;
    logic [8:0]  n_rem_sub;
    logic        n_mul_done;
    logic        n_div_done;
    logic [30:0] n_t_new;
    logic [30:0] n_bs;
    logic [30:0] n_bc;
    logic [31:0] n_ps;
    logic [31:0] n_pc;
    logic [31:0] n_sin;
    logic [31:0] n_cos;

    assign n_frac   = i_req.phase[29:0];
    assign n_mirror = n_frac > EIGHTH_TURN;
    assign n_fold_w = Q30_ONE - {1'b0, n_frac};
    assign n_fold   = n_mirror ? n_fold_w[29:0] : n_frac;

    always_comb begin
        n_ma = '0;
        n_mb = '0;
        unique case (r_state)
            SC_XMUL: begin
                n_ma = {34'd0, r_fold};
                n_mb = PI_Q30;
            end
            SC_X2MUL: begin
                n_ma = {33'd0, r_x};
                n_mb = {1'b0, r_x};
            end
            SC_SMUL, SC_CMUL: begin
                n_ma = {33'd0, r_x2};
                n_mb = {1'b0, r_t};
            end
            SC_SNMUL: begin
                n_ma = {33'd0, r_x};
                n_mb = {1'b0, r_t};
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    assign n_dden     = (r_state == SC_SDIV) ? sin_divisor(r_k) : cos_divisor(r_k);
    assign n_xsum     = r_acc + 64'h0000_0000_4000_0000;
    assign n_x2sum    = r_acc + 64'h0000_0000_2000_0000;
    assign n_rem_sh   = {r_rem, r_dn[31]};
    assign n_ge       = n_rem_sh >= {1'b0, r_dd};
    assign n_rem_sub  = n_rem_sh - {1'b0, r_dd};
    assign n_mul_done = r_mbusy && (r_mb == 32'd0);
    assign n_div_done = r_dbusy && (r_dcnt == 6'd0);
    assign n_t_new    = Q30_ONE - r_dn[30:0];

    // Undo the mirror, then rotate by quadrant.
    assign n_bs = r_mirror ? n_t_new : r_sn;
    assign n_bc = r_mirror ? r_sn : n_t_new;
    assign n_ps = {1'b0, n_bs};
    assign n_pc = {1'b0, n_bc};

    always_comb begin
        unique case (r_quad)
            2'd0: begin
                n_sin = n_ps;
                n_cos = n_pc;
            end
            2'd1: begin
                n_sin = n_pc;
                n_cos = 32'd0 - n_ps;
            end
            2'd2: begin
                n_sin = 32'd0 - n_ps;
                n_cos = 32'd0 - n_pc;
            end
            default: begin
                n_sin = 32'd0 - n_pc;
                n_cos = n_ps;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SC_IDLE;
            r_go_mul <= 1'b0;
            r_go_div <= 1'b0;
            r_mbusy  <= 1'b0;
            r_dbusy  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_go_mul <= 1'b0;
            r_go_div <= 1'b0;
            r_done   <= 1'b0;

            // Shift-add multiplier, one multiplier bit per cycle.
            if (r_go_mul) begin
                r_ma    <= n_ma;
                r_mb    <= n_mb;
                r_acc   <= '0;
                r_mbusy <= 1'b1;
            end else if (r_mbusy) begin
                if (r_mb == 32'd0) begin
                    r_mbusy <= 1'b0;
                end else begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma <= {r_ma[62:0], 1'b0};
                    r_mb <= {1'b0, r_mb[31:1]};
                end
            end

            // Restoring divider, one quotient bit per cycle.
            if (r_go_div) begin
                r_dn    <= r_acc[61:30];
                r_dd    <= n_dden;
                r_rem   <= '0;
                r_dcnt  <= 6'd32;
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                if (r_dcnt == 6'd0) begin
                    r_dbusy <= 1'b0;
                end else begin
                    r_rem  <= n_ge ? n_rem_sub[7:0] : n_rem_sh[7:0];
                    r_dn   <= {r_dn[30:0], n_ge};
                    r_dcnt <= r_dcnt - 6'd1;
                end
            end

            unique case (r_state)
                SC_IDLE: begin
                    if (i_req.start) begin
                        r_quad   <= i_req.phase[31:30];
                        r_mirror <= n_mirror;
                        r_fold   <= n_fold;
                        r_state  <= SC_XMUL;
                        r_go_mul <= 1'b1;
                    end
                end
                SC_XMUL: begin
                    if (n_mul_done) begin
                        r_x      <= n_xsum[61:31];
                        r_state  <= SC_X2MUL;
                        r_go_mul <= 1'b1;
                    end
                end
                SC_X2MUL: begin
                    if (n_mul_done) begin
                        r_x2     <= n_x2sum[60:30];
                        r_t      <= Q30_ONE;
                        r_k      <= 3'd0;
                        r_state  <= SC_SMUL;
                        r_go_mul <= 1'b1;
                    end
                end
                SC_SMUL: begin
                    if (n_mul_done) begin
                        r_state  <= SC_SDIV;
                        r_go_div <= 1'b1;
                    end
                end
                SC_SDIV: begin
                    if (n_div_done) begin
                        r_t <= n_t_new;
                        if (r_k == 3'd4) begin
                            r_state <= SC_SNMUL;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= SC_SMUL;
                        end
                        r_go_mul <= 1'b1;
                    end
                end
                SC_SNMUL: begin
                    if (n_mul_done) begin
                        r_sn     <= r_acc[60:30];
                        r_t      <= Q30_ONE;
                        r_k      <= 3'd0;
                        r_state  <= SC_CMUL;
                        r_go_mul <= 1'b1;
                    end
                end
                SC_CMUL: begin
                    if (n_mul_done) begin
                        r_state  <= SC_CDIV;
                        r_go_div <= 1'b1;
                    end
                end
                SC_CDIV: begin
                    if (n_div_done) begin
                        if (r_k == 3'd5) begin
                            r_sin   <= n_sin;
                            r_cos   <= n_cos;
                            r_done  <= 1'b1;
                            r_state <= SC_IDLE;
                        end else begin
                            r_t      <= n_t_new;
                            r_k      <= r_k + 3'd1;
                            r_state  <= SC_CMUL;
                            r_go_mul <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= SC_IDLE;
                end
            endcase
        end
    end

    assign o_res.done    = r_done;
    assign o_res.sin_q30 = r_sin;
    assign o_res.cos_q30 = r_cos;

endmodule
`default_nettype wire

### hw/rtl/planar_odometry_integrator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Planar odometry integrator
// Dead-reckoning pose integrator for a unicycle robot with exact arc
// integration, fixed-point pose and yaw-only quaternion output.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one beat per tick or pose load
// (i_in_valid / o_in_stall); the output channel returns one beat per input
// beat with the updated pose and quaternion (o_out_valid / i_out_stall).
// All arithmetic runs through bit-serial shift-add multipliers and
// restoring dividers, so an item occupies the block for many cycles.
// One sine and cosine evaluation runs eleven serial divisions and fourteen
// serial multiplications in poi_sincos. A pose load needs one evaluation,
// a straight tick two plus serial products, and an arc tick three
// evaluations plus serial products and quotients.
// One item is processed at a time; o_in_stall is high while it is at work.
// The result sits in an output register, so the next beat is accepted while
// the previous result waits; if the receiver still stalls when the next
// result is ready, the block holds it internally until the register frees.
// A synchronous reset clears the pose to zero and empties the output.
// ----------------------------------------------------------------------------
module planar_odometry_integrator
    import poi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic signed [15:0] i_linear_velocity,
    input  logic signed [15:0] i_angular_velocity,
    input  logic        [15:0] i_time_step,
    input  logic signed [31:0] i_load_x,
    input  logic signed [31:0] i_load_y,
    input  logic        [15:0] i_load_heading,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic        [15:0] o_heading,
    output logic signed [15:0] o_quat_z,
    output logic signed [15:0] o_quat_w
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'h001,
        ST_SC0   = 12'h002,
        ST_SMUL1 = 12'h004,
        ST_SMUL2 = 12'h008,
        ST_WT    = 12'h010,
        ST_DMUL  = 12'h020,
        ST_SC1   = 12'h040,
        ST_ANUM  = 12'h080,
        ST_ADIV  = 12'h100,
        ST_UPD   = 12'h200,
        ST_QSC   = 12'h400,
        ST_FIN   = 12'h800
    } t_state;

    // Saturate a 41-bit sum to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic [40:0] s);
        logic [31:0] r;
        if (s[40:31] == 10'h000 || s[40:31] == 10'h3FF) begin
            r = s[31:0];
        end else if (s[40]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    // Round a Q30 value to Q15, half away from zero, clamping +1.0.
    function automatic logic [15:0] to_q15(input logic [31:0] v);
        logic [31:0] m;
        logic [31:0] s;
        logic [16:0] q;
        logic [16:0] nq;
        logic [15:0] r;
        m  = v[31] ? (32'd0 - v) : v;
        s  = m + 32'h0000_4000;
        q  = s[31:15];
        nq = 17'd0 - q;
        if (v[31]) begin
            r = nq[15:0];
        end else if (q[16] || q[15]) begin
            r = 16'h7FFF;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

    t_state      r_state;
    logic        r_go_mul;
    logic        r_go_div;
    logic        r_go_sc;
    logic        r_pass;
    logic [15:0] r_v;
    logic [15:0] r_w;
    logic [15:0] r_t;
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [15:0] r_yaw;
    logic [31:0] r_s0;
    logic [31:0] r_c0;
    logic [31:0] r_s1;
    logic [31:0] r_c1;
    logic [31:0] r_p1;
    logic [39:0] r_dx;
    logic [39:0] r_dy;
    logic [15:0] r_qz;
    logic [15:0] r_qw;
    logic [63:0] r_ma;
    logic [31:0] r_mb;
    logic [63:0] r_acc;
    logic        r_mbusy;
    logic [47:0] r_dn;
    logic [25:0] r_dd;
    logic [25:0] r_rem;
    logic [5:0]  r_dcnt;
    logic        r_dbusy;
    logic        r_out_valid;
    logic [31:0] r_out_x;
    logic [31:0] r_out_y;
    logic [15:0] r_out_h;
    logic [15:0] r_out_qz;
    logic [15:0] r_out_qw;

    t_sc_req     n_sc_req;
    t_sc_res     n_sc_res;
    logic        n_accept;
    logic [15:0] n_v_mag;
    logic [15:0] n_w_mag;
    logic [31:0] n_c0_mag;
    logic [31:0] n_s0_mag;
    logic [32:0] n_diff;
    logic [32:0] n_diff_mag;
    logic [63:0] n_ma;
    logic [31:0] n_mb;
    logic [47:0] n_dnum;
    logic [25:0] n_dden;
    logic        n_mul_done;
    logic        n_div_done;
    logic [26:0] n_rem_sh;
    logic        n_ge;
    logic [26:0] n_rem_sub;
    logic [63:0] n_str_sum;
    logic [25:0] n_str_mag;
    logic        n_str_neg;
    logic [39:0] n_str_val;
    logic        n_arc_neg;
    logic [39:0] n_arc_val;
    logic [63:0] n_dm_sum;
    logic [31:0] n_dm;
    logic [31:0] n_d;
    logic [31:0] n_p1;
    logic [31:0] n_yaw_sum;
    logic [40:0] n_xsum;
    logic [40:0] n_ysum;

    assign n_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    // Sign-magnitude forms for the unsigned serial units.
    assign n_v_mag    = r_v[15] ? (16'd0 - r_v) : r_v;
    assign n_w_mag    = r_w[15] ? (16'd0 - r_w) : r_w;
    assign n_c0_mag   = r_c0[31] ? (32'd0 - r_c0) : r_c0;
    assign n_s0_mag   = r_s0[31] ? (32'd0 - r_s0) : r_s0;
    assign n_diff     = r_pass ? ({r_c0[31], r_c0} - {r_c1[31], r_c1})
                               : ({r_s1[31], r_s1} - {r_s0[31], r_s0});
    assign n_diff_mag = n_diff[32] ? (33'd0 - n_diff) : n_diff;

    always_comb begin
        n_ma = '0;
        n_mb = '0;
        unique case (r_state)
            ST_SMUL1: begin
                n_ma = {32'd0, (r_pass ? n_s0_mag : n_c0_mag)};
                n_mb = {16'd0, r_t};
            end
            ST_SMUL2: begin
                n_ma = r_acc;
                n_mb = {16'd0, n_v_mag};
            end
            ST_WT: begin
                n_ma = {48'd0, n_w_mag};
                n_mb = {16'd0, r_t};
            end
            ST_DMUL: begin
                n_ma = {34'd0, INV_TWO_PI_Q32};
                n_mb = r_acc[31:0];
            end
            ST_ANUM: begin
                n_ma = {32'd0, n_diff_mag[31:0]};
                n_mb = {16'd0, n_v_mag};
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    // Arc quotient: (|num| + den/2) / den with den = |w| * 1024.
    assign n_dnum     = r_acc[47:0] + {23'd0, n_w_mag, 9'd0};
    assign n_dden     = {n_w_mag, 10'd0};
    assign n_mul_done = r_mbusy && (r_mb == 32'd0);
    assign n_div_done = r_dbusy && (r_dcnt == 6'd0);
    assign n_rem_sh   = {r_rem, r_dn[47]};
    assign n_ge       = n_rem_sh >= {1'b0, r_dd};
    assign n_rem_sub  = n_rem_sh - {1'b0, r_dd};

    // Straight move: round(v * cos * t / 2^38) for x, with sin for y, half away from zero.
    assign n_str_sum = r_acc + 64'h0000_0020_0000_0000;
    assign n_str_mag = n_str_sum[63:38];
    assign n_str_neg = r_v[15] ^ (r_pass ? r_s0[31] : r_c0[31]);
    assign n_str_val = n_str_neg ? (40'd0 - {14'd0, n_str_mag}) : {14'd0, n_str_mag};

    assign n_arc_neg = r_v[15] ^ n_diff[32] ^ r_w[15];
    assign n_arc_val = n_arc_neg ? (40'd0 - r_dn[39:0]) : r_dn[39:0];

    // Turn increment and end phase of the arc.
    assign n_dm_sum  = r_acc + 64'h0000_0000_0800_0000;
    assign n_dm      = n_dm_sum[59:28];
    assign n_d       = r_w[15] ? (32'd0 - n_dm) : n_dm;
    assign n_p1      = {r_yaw, 16'd0} + n_d;
    assign n_yaw_sum = r_p1 + 32'h0000_8000;

    assign n_xsum = {{9{r_x[31]}}, r_x} + {r_dx[39], r_dx};
    assign n_ysum = {{9{r_y[31]}}, r_y} + {r_dy[39], r_dy};

    always_comb begin
        n_sc_req.start = r_go_sc;
        unique case (r_state)
            ST_SC0:  n_sc_req.phase = {r_yaw, 16'd0};
            ST_SC1:  n_sc_req.phase = r_p1;
            default: n_sc_req.phase = {1'b0, r_yaw, 15'd0};
        endcase
    end

    poi_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_sc_req),
        .o_res   (n_sc_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_go_mul    <= 1'b0;
            r_go_div    <= 1'b0;
            r_go_sc     <= 1'b0;
            r_mbusy     <= 1'b0;
            r_dbusy     <= 1'b0;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_yaw       <= '0;
        end else begin
            r_go_mul <= 1'b0;
            r_go_div <= 1'b0;
            r_go_sc  <= 1'b0;

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // Shift-add multiplier, one multiplier bit per cycle.
            if (r_go_mul) begin
                r_ma    <= n_ma;
                r_mb    <= n_mb;
                r_acc   <= '0;
                r_mbusy <= 1'b1;
            end else if (r_mbusy) begin
                if (r_mb == 32'd0) begin
                    r_mbusy <= 1'b0;
                end else begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma <= {r_ma[62:0], 1'b0};
                    r_mb <= {1'b0, r_mb[31:1]};
                end
            end

            // Restoring divider, one quotient bit per cycle.
            if (r_go_div) begin
                r_dn    <= n_dnum;
                r_dd    <= n_dden;
                r_rem   <= '0;
                r_dcnt  <= 6'd48;
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                if (r_dcnt == 6'd0) begin
                    r_dbusy <= 1'b0;
                end else begin
                    r_rem  <= n_ge ? n_rem_sub[25:0] : n_rem_sh[25:0];
                    r_dn   <= {r_dn[46:0], n_ge};
                    r_dcnt <= r_dcnt - 6'd1;
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_pass <= 1'b0;
                        if (i_operation) begin
                            r_x     <= i_load_x;
                            r_y     <= i_load_y;
                            r_yaw   <= i_load_heading;
                            r_state <= ST_QSC;
                        end else begin
                            r_v     <= i_linear_velocity;
                            r_w     <= i_angular_velocity;
                            r_t     <= i_time_step;
                            r_state <= ST_SC0;
                        end
                        r_go_sc <= 1'b1;
                    end
                end
                ST_SC0: begin
                    if (n_sc_res.done) begin
                        r_s0     <= n_sc_res.sin_q30;
                        r_c0     <= n_sc_res.cos_q30;
                        r_state  <= (r_w == 16'd0) ? ST_SMUL1 : ST_WT;
                        r_go_mul <= 1'b1;
                    end
                end
                ST_SMUL1: begin
                    if (n_mul_done) begin
                        r_state  <= ST_SMUL2;
                        r_go_mul <= 1'b1;
                    end
                end
                ST_SMUL2: begin
                    if (n_mul_done) begin
                        if (r_pass) begin
                            r_dy    <= n_str_val;
                            r_state <= ST_UPD;
                        end else begin
                            r_dx     <= n_str_val;
                            r_pass   <= 1'b1;
                            r_state  <= ST_SMUL1;
                            r_go_mul <= 1'b1;
                        end
                    end
                end
                ST_WT: begin
                    if (n_mul_done) begin
                        r_state  <= ST_DMUL;
                        r_go_mul <= 1'b1;
                    end
                end
                ST_DMUL: begin
                    if (n_mul_done) begin
                        r_p1    <= n_p1;
                        r_state <= ST_SC1;
                        r_go_sc <= 1'b1;
                    end
                end
                ST_SC1: begin
                    if (n_sc_res.done) begin
                        r_s1     <= n_sc_res.sin_q30;
                        r_c1     <= n_sc_res.cos_q30;
                        r_state  <= ST_ANUM;
                        r_go_mul <= 1'b1;
                    end
                end
                ST_ANUM: begin
                    if (n_mul_done) begin
                        r_state  <= ST_ADIV;
                        r_go_div <= 1'b1;
                    end
                end
                ST_ADIV: begin
                    if (n_div_done) begin
                        if (r_pass) begin
                            r_dy    <= n_arc_val;
                            r_yaw   <= n_yaw_sum[31:16];
                            r_state <= ST_UPD;
                        end else begin
                            r_dx     <= n_arc_val;
                            r_pass   <= 1'b1;
                            r_state  <= ST_ANUM;
                            r_go_mul <= 1'b1;
                        end
                    end
                end
                ST_UPD: begin
                    r_x     <= sat32(n_xsum);
                    r_y     <= sat32(n_ysum);
                    r_state <= ST_QSC;
                    r_go_sc <= 1'b1;
                end
                ST_QSC: begin
                    if (n_sc_res.done) begin
                        r_qz    <= to_q15(n_sc_res.sin_q30);
                        r_qw    <= to_q15(n_sc_res.cos_q30);
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // Wait until the output register is empty or being drained.
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_x     <= r_x;
                        r_out_y     <= r_y;
                        r_out_h     <= r_yaw;
                        r_out_qz    <= r_qz;
                        r_out_qw    <= r_qw;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_heading   = r_out_h;
    assign o_quat_z    = r_out_qz;
    assign o_quat_w    = r_out_qw;

endmodule
`default_nettype wire
